/* src/kbct_pkg.sv */
// ----------------------------------------------------------------------------
// kbct_pkg: shared types and constants for the keypad BCD countdown timer
// Digit cell layout, key codes, section codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package kbct_pkg;

   // Widths
   localparam int NUM_CELLS  = 6;
   localparam int DIGIT_W    = 4;
   localparam int KIND_W     = 3;
   localparam int CURSOR_W   = 3;
   localparam int SECTION_W  = 2;
   localparam int TENS_W     = 3;   // minutes/seconds tens digit on the output

   // Key codes
   localparam logic [KIND_W-1:0] KIND_DIGIT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ENTER = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;
   localparam logic [KIND_W-1:0] KIND_START = 3'd5;
   localparam logic [KIND_W-1:0] KIND_TICK  = 3'd6;

   // Section codes
   localparam logic [SECTION_W-1:0] SEC_HOURS   = 2'd0;
   localparam logic [SECTION_W-1:0] SEC_MINUTES = 2'd1;
   localparam logic [SECTION_W-1:0] SEC_SECONDS = 2'd2;

   // Cursor columns
   localparam logic [CURSOR_W-1:0] COL_HOURS_TENS   = 3'd0;
   localparam logic [CURSOR_W-1:0] COL_MINUTES_TENS = 3'd3;
   localparam logic [CURSOR_W-1:0] COL_SECONDS_TENS = 3'd6;

   // Digit limits
   localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
   localparam logic [DIGIT_W-1:0] TENS_LIMIT = 4'd6;   // refused at MM/SS tens
   localparam logic [DIGIT_W-1:0] TENS_MAX   = 4'd5;

   // Cell order: hours tens, hours ones, minutes tens, minutes ones,
   // seconds tens, seconds ones. Borrow runs from the last cell to the first.
   localparam logic [CURSOR_W-1:0] CELL_COL [NUM_CELLS] =
      '{3'd0, 3'd1, 3'd3, 3'd4, 3'd6, 3'd7};
   localparam logic [DIGIT_W-1:0] CELL_RELOAD [NUM_CELLS] =
      '{DIGIT_MAX, DIGIT_MAX, TENS_MAX, DIGIT_MAX, TENS_MAX, DIGIT_MAX};

   // Per-cell edit controls
   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctrl_type;

   // Editor and run status
   typedef struct packed {
      logic [CURSOR_W-1:0]  cursor;
      logic [SECTION_W-1:0] section;
      logic                 counting;
      logic                 alarm;
   } status_type;

   // One result record
   typedef struct packed {
      logic [NUM_CELLS-1:0][DIGIT_W-1:0] digits;
      status_type                        status;
      logic                              ignored;
   } rsp_type;

   // First column of a section
   function automatic logic [CURSOR_W-1:0] section_base(input logic [SECTION_W-1:0] sec);
      logic [CURSOR_W-1:0] col;
      if (sec == SEC_MINUTES) begin
         col = COL_MINUTES_TENS;
      end else if (sec == SEC_SECONDS) begin
         col = COL_SECONDS_TENS;
      end else begin
         col = COL_HOURS_TENS;
      end
      return col;
   endfunction

endpackage

`default_nettype wire

/* src/kbct_digit_cell.sv */
// ----------------------------------------------------------------------------
// kbct_digit_cell: one BCD digit of the countdown chain
// Holds a digit, takes edits, decrements on borrow-in and passes borrow,
// all-zero and changed flags on to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module kbct_digit_cell (
   input  wire                                  clock,
   input  wire                                  reset,
   input  kbct_pkg::cell_ctrl_type              ctrl,
   input  wire  [kbct_pkg::DIGIT_W-1:0]         wr_value,
   input  wire  [kbct_pkg::DIGIT_W-1:0]         reload,
   input  wire                                  borrow_in,
   input  wire                                  zero_in,
   input  wire                                  changed_in,
   output logic [kbct_pkg::DIGIT_W-1:0]         digit_next,
   output logic                                 borrow_out,
   output logic                                 zero_out,
   output logic                                 changed_out
);
   import kbct_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic               is_zero;

   assign is_zero = (digit_ff == '0);

   // Next digit: clear, load, or decrement with borrow
   always_comb begin
      digit_in   = digit_ff;
      borrow_out = 1'b0;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.load) begin
         digit_in = wr_value;
      end else if (borrow_in) begin
         if (is_zero) begin
            digit_in   = reload;
            borrow_out = 1'b1;
         end else begin
            digit_in = digit_ff - DIGIT_W'(1);
         end
      end
   end

   assign zero_out    = zero_in & is_zero;
   assign changed_out = changed_in | (digit_in != digit_ff);
   assign digit_next  = digit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

endmodule

`default_nettype wire

/* src/kbct_ctrl.sv */
// ----------------------------------------------------------------------------
// kbct_ctrl: key decoder and editor/run state
// Holds cursor, section, counting and alarm; drives the digit cell controls
// and starts the borrow chain on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kbct_ctrl (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          accept,
   input  wire  [kbct_pkg::KIND_W-1:0]                  kind,
   input  wire  [kbct_pkg::DIGIT_W-1:0]                 digit,
   input  wire                                          all_zero,
   output kbct_pkg::cell_ctrl_type [kbct_pkg::NUM_CELLS-1:0] cell_ctrl,
   output logic                                         dec_start,
   output kbct_pkg::status_type                         status_cur,
   output kbct_pkg::status_type                         status_next
);
   import kbct_pkg::*;

   logic [CURSOR_W-1:0]  cursor_ff,   cursor_in;
   logic [SECTION_W-1:0] section_ff,  section_in;
   logic                 counting_ff, counting_in;
   logic                 alarm_ff,    alarm_in;
   logic [CURSOR_W-1:0]  base;
   logic                 tens_col;
   logic                 digit_ok;

   assign base     = section_base(section_ff);
   assign tens_col = ((section_ff == SEC_MINUTES) && (cursor_ff == COL_MINUTES_TENS)) ||
                     ((section_ff == SEC_SECONDS) && (cursor_ff == COL_SECONDS_TENS));
   assign digit_ok = (digit <= DIGIT_MAX) && !((digit >= TENS_LIMIT) && tens_col);

   // Key decode and next state
   always_comb begin
      cursor_in   = cursor_ff;
      section_in  = section_ff;
      counting_in = counting_ff;
      alarm_in    = alarm_ff;
      dec_start   = 1'b0;
      cell_ctrl   = '0;
      if (accept) begin
         if (counting_ff) begin
            unique case (kind)
               KIND_CLEAR: begin
                  counting_in = 1'b0;
               end
               KIND_TICK: begin
                  if (all_zero) begin
                     alarm_in    = 1'b1;
                     counting_in = 1'b0;
                  end else begin
                     dec_start = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end else begin
            unique case (kind) inside
               KIND_DIGIT: begin
                  if (digit_ok) begin
                     for (int i = 0; i < NUM_CELLS; i++) begin
                        cell_ctrl[i].load = (cursor_ff == CELL_COL[i]);
                     end
                  end
               end
               KIND_RIGHT, KIND_LEFT: begin
                  cursor_in = (cursor_ff == base) ? (base + CURSOR_W'(1)) : base;
               end
               KIND_ENTER: begin
                  section_in = (section_ff >= SEC_SECONDS) ? SEC_HOURS
                                                           : (section_ff + SECTION_W'(1));
                  cursor_in  = section_base(section_in);
               end
               KIND_CLEAR: begin
                  for (int i = 0; i < NUM_CELLS; i++) begin
                     cell_ctrl[i].clear = 1'b1;
                  end
                  section_in = SEC_HOURS;
                  cursor_in  = COL_HOURS_TENS;
                  alarm_in   = 1'b0;
               end
               KIND_START: begin
                  if (!all_zero) begin
                     counting_in = 1'b1;
                     section_in  = SEC_HOURS;
                     cursor_in   = COL_HOURS_TENS;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign status_cur  = '{cursor: cursor_ff, section: section_ff,
                          counting: counting_ff, alarm: alarm_ff};
   assign status_next = '{cursor: cursor_in, section: section_in,
                          counting: counting_in, alarm: alarm_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= COL_HOURS_TENS;
         section_ff  <= SEC_HOURS;
         counting_ff <= 1'b0;
         alarm_ff    <= 1'b0;
      end else begin
         cursor_ff   <= cursor_in;
         section_ff  <= section_in;
         counting_ff <= counting_in;
         alarm_ff    <= alarm_in;
      end
   end

endmodule

`default_nettype wire

/* src/kbct_out_queue.sv */
// ----------------------------------------------------------------------------
// kbct_out_queue: two-entry result buffer
// Output register plus skid register, so a new item can be taken while a
// finished result waits for its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module kbct_out_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  kbct_pkg::rsp_type   push_data,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output kbct_pkg::rsp_type   pop_data
);
   import kbct_pkg::*;

   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    push;
   logic    pop;

   assign push_ready = !skid_valid_ff;
   assign push       = push_valid && push_ready;
   assign pop        = head_valid_ff && pop_ready;

   // Head refills from skid first, then from the incoming record
   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign pop_valid = head_valid_ff;
   assign pop_data  = head_ff;

endmodule

`default_nettype wire

/* src/keypad_bcd_countdown_timer.sv */
// ----------------------------------------------------------------------------
// keypad_bcd_countdown_timer: HH:MM:SS countdown set from key events
// Six BCD digit cells in a borrow chain, a key decoder holding cursor,
// section, run and alarm state, and a two-entry result buffer.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   kind, digit
//   rsp_      out        rsp_valid / rsp_ready   six digits, cursor, section,
//                                                running, alarm, ignored
//
// Each transfer on req_ updates the state in the same cycle; its result is
// registered and queued for rsp_; one item per cycle while req_ready is high.
// The result buffer holds two records: req_ready drops only when both are
// full, so a single waiting result does not stall the input.
// Synchronous active-high reset clears all digits, cursor, section and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_bcd_countdown_timer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_kind,
   input  wire  [3:0]  req_digit,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [3:0]  rsp_hours_tens,
   output logic [3:0]  rsp_hours_ones,
   output logic [2:0]  rsp_minutes_tens,
   output logic [3:0]  rsp_minutes_ones,
   output logic [2:0]  rsp_seconds_tens,
   output logic [3:0]  rsp_seconds_ones,
   output logic [2:0]  rsp_cursor_pos,
   output logic [1:0]  rsp_section,
   output logic        rsp_running,
   output logic        rsp_alarm,
   output logic        rsp_ignored
);
   import kbct_pkg::*;

   logic                              accept;
   cell_ctrl_type [NUM_CELLS-1:0]     cell_ctrl;
   logic                              dec_start;
   status_type                        status_cur;
   status_type                        status_next;
   logic [NUM_CELLS:0]                borrow_chain;
   logic [NUM_CELLS:0]                zero_chain;
   logic [NUM_CELLS:0]                changed_chain;
   logic [NUM_CELLS-1:0][DIGIT_W-1:0] digits_next;
   logic                              all_zero;
   rsp_type                           rsp_rec;
   rsp_type                           rsp_q;

   assign accept = req_valid && req_ready;

   // Key decoder and editor state
   kbct_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_kind),
      .digit       (req_digit),
      .all_zero    (all_zero),
      .cell_ctrl   (cell_ctrl),
      .dec_start   (dec_start),
      .status_cur  (status_cur),
      .status_next (status_next)
   );

   // Digit chain: borrow, zero and changed flags run from seconds ones up
   assign borrow_chain[NUM_CELLS]  = dec_start;
   assign zero_chain[NUM_CELLS]    = 1'b1;
   assign changed_chain[NUM_CELLS] = 1'b0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      kbct_digit_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[i]),
         .wr_value    (req_digit),
         .reload      (CELL_RELOAD[i]),
         .borrow_in   (borrow_chain[i+1]),
         .zero_in     (zero_chain[i+1]),
         .changed_in  (changed_chain[i+1]),
         .digit_next  (digits_next[i]),
         .borrow_out  (borrow_chain[i]),
         .zero_out    (zero_chain[i]),
         .changed_out (changed_chain[i])
      );
   end

   assign all_zero = zero_chain[0];

   // Result record: state after the item
   assign rsp_rec.digits  = digits_next;
   assign rsp_rec.status  = status_next;
   assign rsp_rec.ignored = !(changed_chain[0] || (status_next != status_cur));

   kbct_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (rsp_rec),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_q)
   );

   assign rsp_hours_tens   = rsp_q.digits[0];
   assign rsp_hours_ones   = rsp_q.digits[1];
   assign rsp_minutes_tens = rsp_q.digits[2][TENS_W-1:0];
   assign rsp_minutes_ones = rsp_q.digits[3];
   assign rsp_seconds_tens = rsp_q.digits[4][TENS_W-1:0];
   assign rsp_seconds_ones = rsp_q.digits[5];
   assign rsp_cursor_pos   = rsp_q.status.cursor;
   assign rsp_section      = rsp_q.status.section;
   assign rsp_running      = rsp_q.status.counting;
   assign rsp_alarm        = rsp_q.status.alarm;
   assign rsp_ignored      = rsp_q.ignored;

`ifndef SYNTHESIS
   // A countdown never borrows past the hours tens digit
   a_no_top_borrow: assert property (@(posedge clock) disable iff (reset)
      !borrow_chain[0])
      else $error("borrow out of hours tens digit");

   // Idle clear leaves all digits at zero
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (accept && !status_cur.counting && (req_kind == KIND_CLEAR)) |=> all_zero)
      else $error("idle clear did not zero the digits");

   // A tick on a nonzero time keeps the countdown running
   a_tick_keeps_running: assert property (@(posedge clock) disable iff (reset)
      (accept && status_cur.counting && (req_kind == KIND_TICK) && !all_zero)
      |=> status_cur.counting)
      else $error("countdown stopped on a nonzero tick");

   // Section code stays in range
   a_section_range: assert property (@(posedge clock) disable iff (reset)
      (status_cur.section == SEC_HOURS) || (status_cur.section == SEC_MINUTES) ||
      (status_cur.section == SEC_SECONDS))
      else $error("section out of range");

   // A full result buffer always has a result on offer
   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("buffer full with no result on offer");
`endif

endmodule

`default_nettype wire
